// ===== src/foccpi_pkg.sv =====
// Package for the FOC d/q current PI loop: constants, item types, sequencer states.
package foccpi_pkg;

    localparam int ANGLE_TABLE_BITS_DEF = 10;
    localparam int INTEGRAL_WIDTH_DEF   = 32;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PGAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VLIM  = 3'd5;

    localparam logic [16:0] ALPHA_ONE  = 17'd65536;
    localparam logic [31:0] LIND_RST   = 32'd17179869;
    localparam logic [31:0] FLUX_RST   = 32'd671089;
    localparam logic [14:0] VLIM_RST   = 15'd24000;

    // Clarke beta scale 2/sqrt(3) in Q16 (over two), sine polynomial terms
    localparam int CLARKE_K = 37837;
    localparam int SIN_C0   = 51472;
    localparam int SIN_C1   = 21024;
    localparam int SIN_C2   = 2320;
    localparam int MV_PER_V = 1000;

    typedef struct packed {
        logic signed [15:0] phase_a_current;
        logic signed [15:0] phase_b_current;
        logic        [15:0] electrical_angle;
        logic signed [23:0] mechanical_speed;
        logic signed [15:0] q_current_target;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] q_voltage_cmd;
        logic signed [15:0] d_voltage_cmd;
        logic signed [15:0] measured_q_current;
        logic signed [15:0] measured_d_current;
    } t_out_item;

    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLARKE,
        ST_SIN_SQ,
        ST_SIN_C1,
        ST_SIN_C2,
        ST_SIN_C3,
        ST_SIN_END,
        ST_PARK_D0,
        ST_PARK_D1,
        ST_PARK_Q0,
        ST_PARK_Q1,
        ST_FILT_D,
        ST_FILT_Q,
        ST_FILT_END,
        ST_FF_LO,
        ST_FF_R1,
        ST_FF_SC0,
        ST_FF_SC1,
        ST_FF_END,
        ST_CP_LO,
        ST_CP_HI,
        ST_CP_T,
        ST_CP_DEC,
        ST_SUM,
        ST_INT_Q,
        ST_INT_D,
        ST_OUT
    } t_state;

endpackage

// ===== src/foccpi_mul.sv =====
// Shared signed multiplier with registered product.
module foccpi_mul (
    input  logic                                     i_clk,
    input  foccpi_pkg::t_mul_req                     i_req,
    output logic signed [foccpi_pkg::MUL_P_W-1:0]    o_prod
);

    logic signed [foccpi_pkg::MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= i_req.a * i_req.b;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== src/foc_current_pi_loop_unit.sv =====
// Top level of the FOC d/q current PI loop: config registers, sequencer, datapath.
//
//  channel | signals                                  | handshake
//  --------+------------------------------------------+-------------------------
//  in      | i_in_valid, o_in_ready, i_in_item        | valid/ready, one item
//  out     | o_out_valid, i_out_ready, o_out_item     | valid/ready, one item
//  config  | i_cfg_we, i_cfg_idx, i_cfg_data          | write on we, no wait
//
// From acceptance to a valid result, the sequencer issues 26 products
// through one registered 34x25 multiplier, each dependent step taking its
// operand from the product register. The next item is taken in the idle
// step, so a new item is accepted only once the last one has left the steps.
// The input is taken only while the sequencer is idle; the result sits in an
// output register, so the next item is accepted while it waits to be taken.
// A stalled output holds the sequencer in its last step.
// Reset (synchronous, active low) clears filter and integrator state and
// loads the register defaults.
module foc_current_pi_loop_unit #(
    parameter int ANGLE_TABLE_BITS = foccpi_pkg::ANGLE_TABLE_BITS_DEF,
    parameter int INTEGRAL_WIDTH   = foccpi_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  foccpi_pkg::t_in_item                   i_in_item,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output foccpi_pkg::t_out_item                  o_out_item,
    input  logic                                   i_cfg_we,
    input  logic [foccpi_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [foccpi_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int FRAC   = INTEGRAL_WIDTH - 16;
    localparam int RND_SH = (FRAC <= 24) ? 24 - FRAC : 0;
    localparam int LSH    = (FRAC > 24) ? FRAC - 24 : 0;
    localparam int QS     = 16 - ANGLE_TABLE_BITS;
    localparam logic [15:0] ANG_MASK = 16'((32'hFFFF << QS) & 32'hFFFF);
    localparam logic signed [63:0] IMAX = (64'sd1 <<< (INTEGRAL_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] IMIN = -IMAX - 64'sd1;

    localparam int AW = foccpi_pkg::MUL_A_W;
    localparam int BW = foccpi_pkg::MUL_B_W;
    localparam int PW = foccpi_pkg::MUL_P_W;

    // round half up on an arithmetic shift
    function automatic logic signed [63:0] f_rnd(input logic signed [63:0] v, input int s);
        logic signed [63:0] w;
        begin
            if (s == 0) begin
                w = v;
            end else begin
                w = (v + (64'sd1 <<< (s - 1))) >>> s;
            end
            return w;
        end
    endfunction

    function automatic logic signed [15:0] f_sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        begin
            if (v > 64'sd32767) begin
                r = 16'sh7FFF;
            end else if (v < -64'sd32768) begin
                r = 16'sh8000;
            end else begin
                r = 16'(v);
            end
            return r;
        end
    endfunction

    // ---------------- configuration registers ----------------
    logic [23:0] r_pgain;
    logic [23:0] r_igain;
    logic [16:0] r_alpha;
    logic [31:0] r_lind;
    logic [31:0] r_flux;
    logic [14:0] r_vlim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pgain <= '0;
            r_igain <= '0;
            r_alpha <= foccpi_pkg::ALPHA_ONE;
            r_lind  <= foccpi_pkg::LIND_RST;
            r_flux  <= foccpi_pkg::FLUX_RST;
            r_vlim  <= foccpi_pkg::VLIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                foccpi_pkg::CFG_PGAIN: r_pgain <= i_cfg_data[23:0];
                foccpi_pkg::CFG_IGAIN: r_igain <= i_cfg_data[23:0];
                foccpi_pkg::CFG_ALPHA: r_alpha <= i_cfg_data[16:0];
                foccpi_pkg::CFG_LIND:  r_lind  <= i_cfg_data;
                foccpi_pkg::CFG_FLUX:  r_flux  <= i_cfg_data;
                foccpi_pkg::CFG_VLIM:  r_vlim  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    foccpi_pkg::t_state r_state, n_state;
    foccpi_pkg::t_mul_req w_req;
    logic signed [PW-1:0] w_prod;

    logic r_out_valid;
    foccpi_pkg::t_out_item r_out;

    // captured item
    logic signed [15:0] r_ia, r_ib, r_iqs;
    logic        [15:0] r_ang;
    logic signed [23:0] r_spd;

    // working registers
    logic                  r_sel;    // 0: sine pass, 1: cosine pass
    logic signed [63:0]    r_acc;
    logic        [14:0]    r_x2;
    logic signed [16:0]    r_be;
    logic signed [17:0]    r_sn, r_cs;
    logic signed [15:0]    r_d, r_q;
    logic signed [16:0]    r_eq, r_ed;
    logic signed [26:0]    r_pq, r_pd;
    logic signed [35:0]    r_lo;
    logic signed [35:0]    r_ff;
    logic signed [32:0]    r_t;
    logic signed [39:0]    r_vq, r_vd;

    // loop state
    logic signed [15:0]               r_fd, r_fq;
    logic signed [INTEGRAL_WIDTH-1:0] r_intq, r_intd;

    logic w_in_acc, w_slot_free;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == foccpi_pkg::ST_IDLE);

    // sine argument for the current pass
    logic [15:0] w_pang;
    logic [14:0] w_u;
    logic        w_neg;
    logic [16:0] w_fa;
    always_comb begin
        w_pang = (r_ang & ANG_MASK) + (r_sel ? 16'd16384 : 16'd0);
        w_u    = w_pang[14] ? 15'(15'd16384 - {1'b0, w_pang[13:0]}) : {1'b0, w_pang[13:0]};
        w_neg  = w_pang[15];
        w_fa   = (r_alpha > foccpi_pkg::ALPHA_ONE) ? foccpi_pkg::ALPHA_ONE : r_alpha;
    end

    logic signed [63:0] w_p64, w_p14, w_pcat, w_inc, w_sumq, w_sumd;
    logic signed [39:0] w_absq, w_absd;
    always_comb begin
        w_p64  = 64'(w_prod);
        w_p14  = w_p64 >>> 14;
        w_pcat = (w_p64 <<< 24) + r_acc;
        w_inc  = f_rnd(w_p64, RND_SH) <<< LSH;
        w_sumq = 64'(r_intq) + w_inc;
        w_sumd = 64'(r_intd) + w_inc;
        w_absq = (r_vq < 0) ? -r_vq : r_vq;
        w_absd = (r_vd < 0) ? -r_vd : r_vd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= foccpi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and multiplier issue
    always_comb begin
        n_state = r_state;
        w_req   = '0;
        unique case (r_state)
            foccpi_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = foccpi_pkg::ST_CLARKE;
                end
            end
            foccpi_pkg::ST_CLARKE: begin
                w_req.en = 1'b1;
                w_req.a  = AW'(18'(r_ia) + (18'(r_ib) <<< 1));
                w_req.b  = BW'(foccpi_pkg::CLARKE_K);
                n_state  = foccpi_pkg::ST_SIN_SQ;
            end
            foccpi_pkg::ST_SIN_SQ: begin
                w_req.en = 1'b1;
                w_req.a  = $signed({{(AW-15){1'b0}}, w_u});
                w_req.b  = $signed({{(BW-15){1'b0}}, w_u});
                n_state  = foccpi_pkg::ST_SIN_C1;
            end
            foccpi_pkg::ST_SIN_C1: begin
                w_req.en = 1'b1;
                w_req.a  = AW'(foccpi_pkg::SIN_C2);
                w_req.b  = $signed({{(BW-15){1'b0}}, w_prod[28:14]});
                n_state  = foccpi_pkg::ST_SIN_C2;
            end
            foccpi_pkg::ST_SIN_C2: begin
                w_req.en = 1'b1;
                w_req.a  = AW'(64'(foccpi_pkg::SIN_C1) - w_p14);
                w_req.b  = $signed({{(BW-15){1'b0}}, r_x2});
                n_state  = foccpi_pkg::ST_SIN_C3;
            end
            foccpi_pkg::ST_SIN_C3: begin
                w_req.en = 1'b1;
                w_req.a  = AW'(64'(foccpi_pkg::SIN_C0) - w_p14);
                w_req.b  = $signed({{(BW-15){1'b0}}, w_u});
                n_state  = foccpi_pkg::ST_SIN_END;
            end
            foccpi_pkg::ST_SIN_END: begin
                n_state = r_sel ? foccpi_pkg::ST_PARK_D0 : foccpi_pkg::ST_SIN_SQ;
            end
            foccpi_pkg::ST_PARK_D0: begin
                w_req.en = 1'b1;
                w_req.a  = AW'(r_ia);
                w_req.b  = BW'(r_cs);
                n_state  = foccpi_pkg::ST_PARK_D1;
            end
            foccpi_pkg::ST_PARK_D1: begin
                w_req.en = 1'b1;
                w_req.a  = AW'(r_be);
                w_req.b  = BW'(r_sn);
                n_state  = foccpi_pkg::ST_PARK_Q0;
            end
            foccpi_pkg::ST_PARK_Q0: begin
                w_req.en = 1'b1;
                w_req.a  = AW'(r_be);
                w_req.b  = BW'(r_cs);
                n_state  = foccpi_pkg::ST_PARK_Q1;
            end
            foccpi_pkg::ST_PARK_Q1: begin
                w_req.en = 1'b1;
                w_req.a  = AW'(r_ia);
                w_req.b  = BW'(r_sn);
                n_state  = foccpi_pkg::ST_FILT_D;
            end
            foccpi_pkg::ST_FILT_D: begin
                w_req.en = 1'b1;
                w_req.a  = $signed({{(AW-17){1'b0}}, w_fa});
                w_req.b  = BW'(17'(r_d) - 17'(r_fd));
                n_state  = foccpi_pkg::ST_FILT_Q;
            end
            foccpi_pkg::ST_FILT_Q: begin
                w_req.en = 1'b1;
                w_req.a  = $signed({{(AW-17){1'b0}}, w_fa});
                w_req.b  = BW'(17'(r_q) - 17'(r_fq));
                n_state  = foccpi_pkg::ST_FILT_END;
            end
            foccpi_pkg::ST_FILT_END: begin
                w_req.en = 1'b1;
                w_req.a  = AW'(r_spd);
                w_req.b  = $signed({1'b0, r_flux[23:0]});
                n_state  = foccpi_pkg::ST_FF_LO;
            end
            foccpi_pkg::ST_FF_LO: begin
                w_req.en = 1'b1;
                w_req.a  = AW'(r_spd);
                w_req.b  = $signed({{(BW-8){1'b0}}, r_flux[31:24]});
                n_state  = foccpi_pkg::ST_FF_R1;
            end
            foccpi_pkg::ST_FF_R1: begin
                w_req.en = 1'b1;
                w_req.a  = $signed({{(AW-24){1'b0}}, r_pgain});
                w_req.b  = BW'(r_eq);
                n_state  = foccpi_pkg::ST_FF_SC0;
            end
            foccpi_pkg::ST_FF_SC0: begin
                w_req.en = 1'b1;
                w_req.a  = AW'(foccpi_pkg::MV_PER_V);
                w_req.b  = $signed({1'b0, r_acc[23:0]});
                n_state  = foccpi_pkg::ST_FF_SC1;
            end
            foccpi_pkg::ST_FF_SC1: begin
                w_req.en = 1'b1;
                w_req.a  = AW'(foccpi_pkg::MV_PER_V);
                w_req.b  = BW'($signed(r_acc[40:24]));
                n_state  = foccpi_pkg::ST_FF_END;
            end
            foccpi_pkg::ST_FF_END: begin
                w_req.en = 1'b1;
                w_req.a  = $signed({{(AW-24){1'b0}}, r_pgain});
                w_req.b  = BW'(r_ed);
                n_state  = foccpi_pkg::ST_CP_LO;
            end
            foccpi_pkg::ST_CP_LO: begin
                w_req.en = 1'b1;
                w_req.a  = AW'(r_spd);
                w_req.b  = $signed({1'b0, r_lind[23:0]});
                n_state  = foccpi_pkg::ST_CP_HI;
            end
            foccpi_pkg::ST_CP_HI: begin
                w_req.en = 1'b1;
                w_req.a  = AW'(r_spd);
                w_req.b  = $signed({{(BW-8){1'b0}}, r_lind[31:24]});
                n_state  = foccpi_pkg::ST_CP_T;
            end
            foccpi_pkg::ST_CP_T: begin
                n_state = foccpi_pkg::ST_CP_DEC;
            end
            foccpi_pkg::ST_CP_DEC: begin
                w_req.en = 1'b1;
                w_req.a  = AW'(r_t);
                w_req.b  = BW'(r_iqs);
                n_state  = foccpi_pkg::ST_SUM;
            end
            foccpi_pkg::ST_SUM: begin
                w_req.en = 1'b1;
                w_req.a  = $signed({{(AW-24){1'b0}}, r_igain});
                w_req.b  = BW'(r_eq);
                n_state  = foccpi_pkg::ST_INT_Q;
            end
            foccpi_pkg::ST_INT_Q: begin
                w_req.en = 1'b1;
                w_req.a  = $signed({{(AW-24){1'b0}}, r_igain});
                w_req.b  = BW'(r_ed);
                n_state  = foccpi_pkg::ST_INT_D;
            end
            foccpi_pkg::ST_INT_D: begin
                n_state = foccpi_pkg::ST_OUT;
            end
            foccpi_pkg::ST_OUT: begin
                if (w_slot_free) begin
                    n_state = foccpi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = foccpi_pkg::ST_IDLE;
            end
        endcase
    end

    foccpi_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_prod (w_prod)
    );

    // working datapath: each step takes the product issued one step earlier
    always_ff @(posedge i_clk) begin
        case (r_state)
            foccpi_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    r_ia  <= i_in_item.phase_a_current;
                    r_ib  <= i_in_item.phase_b_current;
                    r_ang <= i_in_item.electrical_angle;
                    r_spd <= i_in_item.mechanical_speed;
                    r_iqs <= i_in_item.q_current_target;
                    r_sel <= 1'b0;
                end
            end
            foccpi_pkg::ST_SIN_SQ: begin
                if (!r_sel) begin
                    r_be <= 17'(f_rnd(w_p64, 16));
                end
            end
            foccpi_pkg::ST_SIN_C1: r_x2 <= w_prod[28:14];
            foccpi_pkg::ST_SIN_END: begin
                if (r_sel) begin
                    r_cs <= w_neg ? -18'(w_p14) : 18'(w_p14);
                end else begin
                    r_sn  <= w_neg ? -18'(w_p14) : 18'(w_p14);
                    r_sel <= 1'b1;
                end
            end
            foccpi_pkg::ST_PARK_D1: r_acc <= w_p64;
            foccpi_pkg::ST_PARK_Q0: r_d   <= f_sat16(f_rnd(r_acc + w_p64, 15));
            foccpi_pkg::ST_PARK_Q1: r_acc <= w_p64;
            foccpi_pkg::ST_FILT_D:  r_q   <= f_sat16(f_rnd(r_acc - w_p64, 15));
            foccpi_pkg::ST_FF_LO:   r_acc <= w_p64;
            foccpi_pkg::ST_FF_R1:   r_acc <= f_rnd(w_pcat, 16);
            foccpi_pkg::ST_FF_SC0:  r_pq  <= 27'(f_rnd(w_p64, 16));
            foccpi_pkg::ST_FF_SC1:  r_lo  <= 36'(w_p64);
            foccpi_pkg::ST_FF_END:  r_ff  <= 36'(f_rnd((w_p64 <<< 24) + 64'(r_lo), 16));
            foccpi_pkg::ST_CP_LO:   r_pd  <= 27'(f_rnd(w_p64, 16));
            foccpi_pkg::ST_CP_HI:   r_acc <= w_p64;
            foccpi_pkg::ST_CP_T:    r_t   <= 33'(f_rnd(w_pcat, 24));
            foccpi_pkg::ST_SUM: begin
                r_vq <= 40'(64'(r_pq) + f_rnd(64'(r_intq), FRAC) + 64'(r_ff));
                r_vd <= 40'(64'(r_pd) + f_rnd(64'(r_intd), FRAC) - f_rnd(w_p64, 16));
            end
            foccpi_pkg::ST_OUT: begin
                if (w_slot_free) begin
                    r_out.q_voltage_cmd      <= f_sat16(64'(r_vq));
                    r_out.d_voltage_cmd      <= f_sat16(64'(r_vd));
                    r_out.measured_q_current <= r_fq;
                    r_out.measured_d_current <= r_fd;
                end
            end
            default: ;
        endcase
    end

    // filter and integrator state, plus output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fd        <= '0;
            r_fq        <= '0;
            r_intq      <= '0;
            r_intd      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result replaces a taken one in the same cycle
            if (r_state == foccpi_pkg::ST_OUT && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                foccpi_pkg::ST_FILT_Q: begin
                    r_fd <= 16'(64'(r_fd) + f_rnd(w_p64, 16));
                end
                foccpi_pkg::ST_FILT_END: begin
                    r_fq <= 16'(64'(r_fq) + f_rnd(w_p64, 16));
                    r_eq <= 17'(r_iqs) - 17'(64'(r_fq) + f_rnd(w_p64, 16));
                    r_ed <= -17'(r_fd);
                end
                foccpi_pkg::ST_INT_Q: begin
                    if (w_absq < $signed({25'b0, r_vlim})) begin
                        r_intq <= INTEGRAL_WIDTH'((w_sumq > IMAX) ? IMAX :
                                                  ((w_sumq < IMIN) ? IMIN : w_sumq));
                    end
                end
                foccpi_pkg::ST_INT_D: begin
                    if (w_absd < $signed({25'b0, r_vlim})) begin
                        r_intd <= INTEGRAL_WIDTH'((w_sumd > IMAX) ? IMAX :
                                                  ((w_sumd < IMIN) ? IMIN : w_sumd));
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== test/tb_foc_current_pi_loop_unit.sv =====
// Testbench for the FOC d/q current PI loop: random and directed items, scoreboarded.
`timescale 1ns / 1ps

// Scoreboard: mirrors the config registers and the loop state, predicts each
// result from an accepted input item and checks results in order.
class pi_loop_scoreboard;
    // mirrored registers
    longint pgain, igain, alpha, lind, flux, vlim;
    // mirrored loop state
    longint d_filt, q_filt, q_integ, d_integ;
    foccpi_pkg::t_out_item expected_q[$];
    int mismatches;

    function new();
        pgain = 0;
        igain = 0;
        alpha = 65536;
        lind = longint'(foccpi_pkg::LIND_RST);
        flux = longint'(foccpi_pkg::FLUX_RST);
        vlim = longint'(foccpi_pkg::VLIM_RST);
        d_filt = 0;
        q_filt = 0;
        q_integ = 0;
        d_integ = 0;
        mismatches = 0;
    endfunction

    function void write_reg(logic [foccpi_pkg::CFG_IDX_W-1:0] idx,
                            logic [foccpi_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            foccpi_pkg::CFG_PGAIN: pgain = longint'(val[23:0]);
            foccpi_pkg::CFG_IGAIN: igain = longint'(val[23:0]);
            foccpi_pkg::CFG_ALPHA: alpha = longint'(val[16:0]);
            foccpi_pkg::CFG_LIND:  lind  = longint'(val);
            foccpi_pkg::CFG_FLUX:  flux  = longint'(val);
            foccpi_pkg::CFG_VLIM:  vlim  = longint'(val[14:0]);
            default: ;
        endcase
    endfunction

    // round half up by 2^s (floor of x + half)
    function longint round_sh(longint x, int s);
        if (s == 0) return x;
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint clamp(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    // Q15 sine, odd polynomial on the quarter wave
    function longint sine_q15(logic [15:0] p);
        longint u, x2, t;
        u = p[14] ? 16384 - longint'(p[13:0]) : longint'(p[13:0]);
        x2 = (u * u) >>> 14;
        t = foccpi_pkg::SIN_C1 - ((foccpi_pkg::SIN_C2 * x2) >>> 14);
        t = foccpi_pkg::SIN_C0 - ((t * x2) >>> 14);
        t = (t * u) >>> 14;
        return p[15] ? -t : t;
    endfunction

    function longint integrate(longint acc, longint err);
        localparam int FRAC = foccpi_pkg::INTEGRAL_WIDTH_DEF - 16;
        longint hi, inc;
        hi = (longint'(1) <<< (foccpi_pkg::INTEGRAL_WIDTH_DEF - 1)) - 1;
        if (FRAC <= 24) inc = round_sh(err * igain, 24 - FRAC);
        else inc = (err * igain) <<< (FRAC - 24);
        return clamp(acc + inc, -hi - 1, hi);
    endfunction

    // Accepted input item: run one control tick and queue its result.
    function void note_input(foccpi_pkg::t_in_item it);
        localparam int FRAC = foccpi_pkg::INTEGRAL_WIDTH_DEF - 16;
        longint ia, ib, spd, tgt, be, sn, cs, d, q, fa, eq, ed, ff, tc, dec, vq, vd;
        logic [15:0] ang;
        foccpi_pkg::t_out_item r;
        ia = longint'(it.phase_a_current);
        ib = longint'(it.phase_b_current);
        spd = longint'(it.mechanical_speed);
        tgt = longint'(it.q_current_target);
        be = round_sh((ia + 2 * ib) * foccpi_pkg::CLARKE_K, 16);
        ang = it.electrical_angle &
              ~16'((1 << (16 - foccpi_pkg::ANGLE_TABLE_BITS_DEF)) - 1);
        sn = sine_q15(ang);
        cs = sine_q15(ang + 16'd16384);
        d = clamp(round_sh(ia * cs + be * sn, 15), -32768, 32767);
        q = clamp(round_sh(be * cs - ia * sn, 15), -32768, 32767);
        // weight above one acts as bypass
        fa = alpha > 65536 ? 65536 : alpha;
        d_filt = d_filt + round_sh(fa * (d - d_filt), 16);
        q_filt = q_filt + round_sh(fa * (q - q_filt), 16);
        eq = tgt - q_filt;
        ed = -d_filt;
        ff = round_sh(round_sh(spd * flux, 16) * foccpi_pkg::MV_PER_V, 16);
        tc = round_sh(spd * lind, 24);
        dec = -round_sh(tc * tgt, 16);
        vq = round_sh(eq * pgain, 16) + round_sh(q_integ, FRAC) + ff;
        vd = round_sh(ed * pgain, 16) + round_sh(d_integ, FRAC) + dec;
        // freeze on the unsaturated magnitude, equal freezes
        if ((vq < 0 ? -vq : vq) < vlim) q_integ = integrate(q_integ, eq);
        if ((vd < 0 ? -vd : vd) < vlim) d_integ = integrate(d_integ, ed);
        r.q_voltage_cmd = 16'(clamp(vq, -32768, 32767));
        r.d_voltage_cmd = 16'(clamp(vd, -32768, 32767));
        r.measured_q_current = 16'(q_filt);
        r.measured_d_current = 16'(d_filt);
        expected_q.push_back(r);
    endfunction

    function void check_result(foccpi_pkg::t_out_item got);
        foccpi_pkg::t_out_item exp_r;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item: %h", got);
            return;
        end
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: vq %0d/%0d vd %0d/%0d iq %0d/%0d id %0d/%0d (exp/got)",
                    exp_r.q_voltage_cmd, got.q_voltage_cmd,
                    exp_r.d_voltage_cmd, got.d_voltage_cmd,
                    exp_r.measured_q_current, got.measured_q_current,
                    exp_r.measured_d_current, got.measured_d_current);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_foc_current_pi_loop_unit;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              o_in_ready;
    foccpi_pkg::t_in_item              in_item = '0;
    logic                              o_out_valid;
    logic                              out_ready = 1'b0;
    foccpi_pkg::t_out_item             o_out_item;
    logic                              cfg_we = 1'b0;
    logic [foccpi_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [foccpi_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    pi_loop_scoreboard sb = new();
    bit long_hold_req = 1'b0;    // asks the receiver for one long stall

    always #4 i_clk = ~i_clk;

    foc_current_pi_loop_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_item (o_out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Both handshakes are observed at the rising edge; the predictor runs on
    // each accepted input item, the checker on each accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready) sb.note_input(in_item);
            if (o_out_valid && out_ready) sb.check_result(o_out_item);
        end
    end

    // Receiver: a stall pattern that switches between always ready, coin flip
    // and mostly stalled after each run of random length; a long hold on request.
    initial begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                out_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(8, 80);
                end
                left--;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

    // Offer one item and hold it until accepted. Valid stays high afterward;
    // the caller lowers it only when a gap follows.
    task automatic send_item(foccpi_pkg::t_in_item it);
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Wait until every expected result is in, then let the pipeline drain.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [foccpi_pkg::CFG_IDX_W-1:0] idx,
                             logic [foccpi_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // Random field values: extremes now and then, speeds mostly modest so the
    // loop spends time below the voltage limit.
    function automatic foccpi_pkg::t_in_item rand_item();
        foccpi_pkg::t_in_item it;
        it.phase_a_current = ($urandom_range(0, 5) == 0) ?
            ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000) : 16'($urandom);
        it.phase_b_current = ($urandom_range(0, 5) == 0) ?
            ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000) : 16'($urandom);
        it.electrical_angle = 16'($urandom);
        case ($urandom_range(0, 3))
            0: it.mechanical_speed = 24'($urandom);
            1: it.mechanical_speed = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
            default: it.mechanical_speed = 24'(int'($urandom_range(0, 8191)) - 4096);
        endcase
        it.q_current_target = ($urandom_range(0, 2) == 0) ?
            16'($urandom) : 16'(int'($urandom_range(0, 4001)) - 2000);
        return it;
    endfunction

    // Random bursts with random gaps; some stretches run back to back.
    task automatic run_random(int count);
        int burst;
        int sent;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_item(rand_item());
                sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
        end
    endtask

    initial begin
        foccpi_pkg::t_in_item it;
        logic signed [15:0] cur_ext [4];
        logic [15:0] ang_list [6];
        cur_ext = '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1};
        ang_list = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535, 16'd63};

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items at reset settings: current, angle, speed and target
        // extremes, Park saturation with both phases at full scale.
        for (int k = 0; k < 6; k++) begin
            it.phase_a_current = cur_ext[k % 4];
            it.phase_b_current = cur_ext[(k + 1) % 4];
            it.electrical_angle = ang_list[k];
            it.mechanical_speed = (k % 2) ? 24'sh7fffff : 24'sh800000;
            it.q_current_target = (k % 2) ? 16'sh8000 : 16'sh7fff;
            send_item(it);
        end
        it.phase_a_current = 16'sh7fff;
        it.phase_b_current = 16'sh7fff;
        for (int k = 0; k < 6; k++) begin
            it.electrical_angle = ang_list[k];
            send_item(it);
        end
        drain();

        // Gains on, filter live, integrator freeze at a low limit.
        write_reg(foccpi_pkg::CFG_PGAIN, 32'h0001_0000);
        write_reg(foccpi_pkg::CFG_IGAIN, 32'h0000_4000);
        write_reg(foccpi_pkg::CFG_ALPHA, 32'd8192);
        write_reg(foccpi_pkg::CFG_VLIM, 32'd3000);
        for (int k = 0; k < 10; k++) begin
            it = rand_item();
            it.mechanical_speed = '0;
            it.q_current_target = (k < 5) ? 16'sh7fff : 16'sh8000;
            send_item(it);
        end
        run_random(150);
        // Long receiver stall while the sender keeps offering items.
        long_hold_req = 1'b1;
        run_random(40);
        // Sender waits for every result before going on.
        drain();
        run_random(60);
        drain();

        // All registers but the filter weight at the top of their range, the weight
        // at zero; integrators run into saturation.
        write_reg(foccpi_pkg::CFG_PGAIN, 32'h00ff_ffff);
        write_reg(foccpi_pkg::CFG_IGAIN, 32'h00ff_ffff);
        write_reg(foccpi_pkg::CFG_ALPHA, 32'd0);
        write_reg(foccpi_pkg::CFG_LIND, 32'hffff_ffff);
        write_reg(foccpi_pkg::CFG_FLUX, 32'hffff_ffff);
        write_reg(foccpi_pkg::CFG_VLIM, 32'h0000_7fff);
        run_random(160);
        drain();

        // Bottom of the range, filter weight above one, and writes to the two
        // unused indices that must change nothing.
        write_reg(foccpi_pkg::CFG_PGAIN, 32'd0);
        write_reg(foccpi_pkg::CFG_IGAIN, 32'd0);
        write_reg(foccpi_pkg::CFG_ALPHA, 32'h0001_ffff);
        write_reg(foccpi_pkg::CFG_LIND, 32'd0);
        write_reg(foccpi_pkg::CFG_FLUX, 32'd0);
        write_reg(foccpi_pkg::CFG_VLIM, 32'd0);
        write_reg(3'd6, 32'hffff_ffff);
        write_reg(3'd7, 32'h1234_5678);
        run_random(120);
        drain();

        // Random settings, with full-width data so the upper bits are ignored.
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(foccpi_pkg::CFG_PGAIN,
                      $urandom_range(0, 3) ? $urandom_range(0, 262143) : $urandom);
            write_reg(foccpi_pkg::CFG_IGAIN, $urandom);
            write_reg(foccpi_pkg::CFG_ALPHA,
                      $urandom_range(0, 1) ? $urandom_range(0, 65536) : $urandom);
            write_reg(foccpi_pkg::CFG_LIND, $urandom);
            write_reg(foccpi_pkg::CFG_FLUX,
                      $urandom_range(0, 1) ? $urandom_range(0, 2000000) : $urandom);
            write_reg(foccpi_pkg::CFG_VLIM, $urandom);
            run_random(120);
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
